FILE: hw/rtl/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

  localparam int unsigned DIVIDEND_W = 8;
  localparam int unsigned DIVISOR_W  = 10;
  localparam int unsigned PHYS_W     = 22;
  localparam int unsigned PAGES_W    = 9;

  typedef enum logic [1:0] {
    KIND_TOP_REG = 2'd0,
    KIND_SLOT_WR = 2'd1,
    KIND_FOUR_8K = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TGT_ROM     = 2'd0,
    TGT_SRAM    = 2'd1,
    TGT_WRAM    = 2'd2,
    TGT_DROPPED = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    CFG_MAPPER_KIND = 2'd0,
    CFG_ROM_PAGES   = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  localparam logic [15:0] REG_PORT_BASE = 16'hFFFC;
  localparam logic [15:0] FIXED_1K_END  = 16'h0400;
  localparam logic [15:0] REG_8K_LAST   = 16'h0003;
  localparam logic [8:0]  PAGES_RESET   = 9'd32;

endpackage : cbm_pkg
`default_nettype wire

FILE: hw/rtl/cbm_mod.sv
// Bit-serial restoring modulo unit for bank page numbers.
`default_nettype none
module cbm_mod (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [cbm_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [cbm_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                done,
  output logic [cbm_pkg::DIVIDEND_W-1:0]      remainder
);
  import cbm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                   run;
  logic [CNT_W-1:0]       cnt;
  logic [DIVIDEND_W-1:0]  shift;
  logic [DIVISOR_W-1:0]   dvs;
  logic [DIVIDEND_W:0]    trial;
  logic [DIVISOR_W-1:0]   trial_ext;
  logic                   fits;
  logic [DIVIDEND_W-1:0]  rem_next;

  always_comb begin
    trial     = {remainder, shift[DIVIDEND_W-1]};
    trial_ext = DIVISOR_W'(trial);
    fits      = trial_ext >= dvs;
    rem_next  = fits ? DIVIDEND_W'(trial_ext - dvs) : DIVIDEND_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (run) begin
      shift     <= shift << 1;
      remainder <= rem_next;
    end
  end

endmodule : cbm_mod
`default_nettype wire

FILE: hw/rtl/cartridge_bank_mapper.sv
// Cartridge ROM bank mapper: decodes one CPU access to ROM, SRAM or work RAM.
// done is registered from the decode state for direct mappings; banked ROM reads go
// through the divide state, where the page modulo runs one bit per cycle in cbm_mod.
// One item at a time: busy stays high until the result is issued.
// The result is shown for one cycle only; the receiver cannot stall.
// Reset: 16K top-register kind, 32 pages, linear bank registers, SRAM flag clear.
`default_nettype none
module cartridge_bank_mapper #(
  parameter int unsigned MAX_ROM_PAGES = 256,
  parameter int unsigned SRAM_BYTES    = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [15:0] cpu_address,
  input  wire logic [7:0]  write_data,
  output logic             done,
  output logic [1:0]       target,
  output logic [21:0]      physical_address,
  output logic             register_written,
  output logic             sram_used,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import cbm_pkg::*;

  state_t      state, state_next;
  kind_t       kind;
  kind_t       kind_eff;
  logic [8:0]  pages;
  logic [8:0]  pages_eff;
  logic [7:0]  bank [4];
  logic        sram_seen;

  logic        op_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic        wide_q;
  target_t     tgt_q;

  target_t     dec_tgt;
  logic [21:0] dec_phys;
  logic        dec_regw;
  logic [1:0]  dec_widx;
  logic        dec_div;
  logic        dec_wide;
  logic [DIVISOR_W-1:0] dec_divisor;
  logic [1:0]  rd_idx;
  logic [7:0]  rd_bank;
  logic        sram_slot;
  logic [15:0] sram_raw;
  logic [15:0] sram_off;
  logic        sram_set;

  logic        div_start;
  logic        div_done;
  logic [DIVIDEND_W-1:0] div_rem;

  assign busy = (state != S_IDLE);

  always_comb begin
    kind_eff = (kind == KIND_UNUSED) ? KIND_TOP_REG : kind;
    if (pages == 9'd0) begin
      pages_eff = 9'd1;
    end else if ({1'b0, pages} > 10'(MAX_ROM_PAGES)) begin
      pages_eff = 9'(MAX_ROM_PAGES);
    end else begin
      pages_eff = pages;
    end
  end

  always_comb begin
    rd_idx    = (kind_eff == KIND_FOUR_8K) ? addr_q[14:13] : 2'(addr_q[15:14] + 2'd1);
    rd_bank   = bank[rd_idx];
    sram_slot = (kind_eff != KIND_FOUR_8K) && (addr_q[15:14] == 2'd2) && bank[0][3];
    sram_raw  = {1'b0, bank[0][2], addr_q[13:0]};
    sram_off  = (sram_raw >= 16'(SRAM_BYTES)) ? 16'(sram_raw - 16'(SRAM_BYTES)) : sram_raw;

    dec_tgt     = TGT_DROPPED;
    dec_phys    = '0;
    dec_regw    = 1'b0;
    dec_widx    = addr_q[1:0];
    dec_div     = 1'b0;
    dec_wide    = 1'b1;
    dec_divisor = DIVISOR_W'(pages_eff);

    if (addr_q[15:14] == 2'd3) begin
      dec_tgt  = TGT_WRAM;
      dec_phys = 22'(addr_q[12:0]);
      if (op_q && (kind_eff == KIND_TOP_REG) && (addr_q >= REG_PORT_BASE)) begin
        dec_regw = 1'b1;
      end
    end else if (sram_slot) begin
      dec_tgt  = TGT_SRAM;
      dec_phys = 22'(sram_off);
    end else if (op_q) begin
      if (kind_eff == KIND_SLOT_WR) begin
        dec_regw = 1'b1;
        dec_widx = 2'(addr_q[15:14] + 2'd1);
      end else if ((kind_eff == KIND_FOUR_8K) && (addr_q <= REG_8K_LAST)) begin
        dec_regw = 1'b1;
      end
    end else if (kind_eff != KIND_FOUR_8K) begin
      dec_tgt = TGT_ROM;
      if ((kind_eff == KIND_TOP_REG) && (addr_q < FIXED_1K_END)) begin
        dec_phys = 22'(addr_q);
      end else begin
        dec_div = 1'b1;
      end
    end else begin
      dec_tgt = TGT_ROM;
      if (addr_q[15:14] == 2'd0) begin
        dec_phys = 22'(addr_q);
      end else begin
        dec_div     = 1'b1;
        dec_wide    = 1'b0;
        dec_divisor = {pages_eff, 1'b0};
      end
    end

    sram_set = dec_regw && (kind_eff != KIND_FOUR_8K) && (dec_widx == 2'd0) && data_q[3];
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (dec_div) begin
          div_start  = 1'b1;
          state_next = S_DIVIDE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (div_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  cbm_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rd_bank),
    .divisor   (dec_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind      <= KIND_TOP_REG;
      pages     <= PAGES_RESET;
      sram_seen <= 1'b0;
      bank[0]   <= 8'd0;
      bank[1]   <= 8'd0;
      bank[2]   <= 8'd1;
      bank[3]   <= 8'd2;
    end else if (cfg_write && (cfg_index == CFG_MAPPER_KIND)) begin
      kind <= kind_t'(cfg_data[1:0]);
      if (kind_t'(cfg_data[1:0]) == KIND_FOUR_8K) begin
        bank[0] <= 8'd4;
        bank[1] <= 8'd5;
        bank[2] <= 8'd2;
        bank[3] <= 8'd3;
      end else begin
        bank[0] <= 8'd0;
        bank[1] <= 8'd0;
        bank[2] <= 8'd1;
        bank[3] <= 8'd2;
      end
    end else if (cfg_write && (cfg_index == CFG_ROM_PAGES)) begin
      pages <= cfg_data;
    end else if ((state == S_DECODE) && dec_regw) begin
      bank[dec_widx] <= data_q;
      if (sram_set) sram_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q   <= opcode;
      addr_q <= cpu_address;
      data_q <= write_data;
    end
    if (state == S_DECODE) begin
      wide_q <= dec_wide;
      tgt_q  <= dec_tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == S_DECODE) && !dec_div) || ((state == S_DIVIDE) && div_done);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DECODE) && !dec_div) begin
      target           <= dec_tgt;
      physical_address <= dec_phys;
      register_written <= dec_regw;
      sram_used        <= sram_seen || sram_set;
    end else if ((state == S_DIVIDE) && div_done) begin
      target           <= tgt_q;
      physical_address <= wide_q ? {div_rem, addr_q[13:0]}
                                 : {1'b0, div_rem, addr_q[12:0]};
      register_written <= 1'b0;
      sram_used        <= sram_seen;
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_div_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVIDE)
    else $error("modulo result outside divide state");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("result issued without an item in flight");

  a_regw_target: assert property (@(posedge clk) disable iff (rst)
    done && register_written |-> target == TGT_WRAM || target == TGT_DROPPED)
    else $error("register write reported with ROM or SRAM target");
`endif

endmodule : cartridge_bank_mapper
`default_nettype wire
